// ----- hw/rtl/command_frame_parser_assert.svh -----
// ----------------------------------------------------------------------------
// Command frame parser assertion macros
// Shared assertion forms clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_PARSER_ASSERT_SVH
`define COMMAND_FRAME_PARSER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define CFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition in one cycle that must be followed by another in the next cycle.
`define CFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/cfp_pkg.sv -----
// ----------------------------------------------------------------------------
// Command frame parser package
// Header bytes, frame positions, command slot map and shared types.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int FRAME_LENGTH_DEF = 20;
  localparam int CMD_COUNT = 12;
  localparam int POS_W = 6;

  localparam logic [7:0] HDR_FIRST = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;

  localparam logic [POS_W-1:0] POS_HUNT = 6'd0;
  localparam logic [POS_W-1:0] POS_SYNC = 6'd1;
  localparam logic [POS_W-1:0] POS_LEN = 6'd2;
  localparam logic [POS_W-1:0] POS_DATA = 6'd3;

  // Payload offset (frame byte minus three) captured into each command slot.
  localparam logic [POS_W-1:0] CMD_INDEX [CMD_COUNT] = '{
    6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd15
  };

  typedef logic [CMD_COUNT-1:0][7:0] cmd_bytes_t;

  typedef struct packed {
    logic at_last;
    logic frame_end;
    logic sum_match;
    logic emit;
  } parse_evt_t;

endpackage

// ----- hw/rtl/cfp_parser.sv -----
// ----------------------------------------------------------------------------
// Command frame parser core
// Tracks the frame position and running sum, captures command bytes and
// flags a frame whose checksum matches.
// ----------------------------------------------------------------------------
module cfp_parser #(
  parameter int FRAME_LENGTH = cfp_pkg::FRAME_LENGTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic [7:0]          rx_byte,
  output cfp_pkg::parse_evt_t evt,
  output cfp_pkg::cmd_bytes_t cmd
);
  import cfp_pkg::*;

  localparam logic [POS_W-1:0] LAST = POS_W'(FRAME_LENGTH - 1);
  localparam logic [7:0] LEN_BYTE = 8'(FRAME_LENGTH);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [7:0]       sum;
  logic [7:0]       sum_next;
  logic [POS_W-1:0] offset;
  logic             capture;
  cmd_bytes_t       cmd_store;

  assign offset  = pos - POS_DATA;
  assign capture = in_fire && (pos >= POS_DATA) && (pos < LAST);
  assign cmd     = cmd_store;

  always_comb begin
    pos_next    = pos;
    sum_next    = sum;
    evt         = '0;
    evt.at_last = (pos == LAST);
    if (in_fire) begin
      case (pos)
        POS_HUNT: begin
          if (rx_byte == HDR_FIRST) begin
            pos_next = POS_SYNC;
            sum_next = rx_byte;
          end
        end
        POS_SYNC: begin
          if (rx_byte == HDR_SECOND) begin
            pos_next = POS_LEN;
            sum_next = sum + rx_byte;
          end else if (rx_byte == HDR_FIRST) begin
            pos_next = POS_SYNC;
            sum_next = rx_byte;
          end else begin
            pos_next = POS_HUNT;
            sum_next = '0;
          end
        end
        POS_LEN: begin
          if (rx_byte == LEN_BYTE) begin
            pos_next = POS_DATA;
            sum_next = sum + rx_byte;
          end else begin
            pos_next = POS_HUNT;
            sum_next = '0;
          end
        end
        default: begin
          if (pos < LAST) begin
            pos_next = pos + 6'd1;
            sum_next = sum + rx_byte;
          end else begin
            evt.frame_end = 1'b1;
            evt.sum_match = (rx_byte == sum);
            evt.emit      = (rx_byte == sum);
            pos_next      = POS_HUNT;
            sum_next      = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_HUNT;
      sum <= '0;
    end else begin
      pos <= pos_next;
      sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CMD_COUNT; i++) begin
      if (capture && (offset == CMD_INDEX[i])) begin
        cmd_store[i] <= rx_byte;
      end
    end
  end

  `include "command_frame_parser_assert.svh"

  `CFP_ASSERT(a_pos_in_frame, pos <= LAST, "Frame position ran past the checksum byte.")
  `CFP_ASSERT(a_hunt_sum_clear, (pos == POS_HUNT) |-> (sum == 8'd0), "Running sum not clear while hunting.")
  `CFP_ASSERT(a_emit_at_end, evt.emit |-> (evt.frame_end && evt.at_last && in_fire), "Frame emitted away from the checksum byte.")

endmodule

// ----- hw/rtl/command_frame_parser.sv -----
// ----------------------------------------------------------------------------
// Command frame parser
// Finds 0xAA 0x55 framed commands in a byte stream and delivers the command
// bytes of each frame whose additive checksum matches.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle on the rx channel and delivers one
// command transfer on the cmd channel in the cycle after the checksum byte of
// a good frame is taken. Frame state and the running sum live in one register
// set. The only stall is on a checksum byte while the previous command
// transfer is still waiting in the output register; as frames are at least
// FRAME_LENGTH bytes long, a consumer that takes each command before the
// checksum byte of the next frame arrives never slows the byte stream.
module command_frame_parser #(
  parameter int FRAME_LENGTH = cfp_pkg::FRAME_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output logic [7:0] depth_hold,
  output logic [7:0] heading_hold,
  output logic [7:0] fore_aft,
  output logic [7:0] lateral,
  output logic [7:0] vertical,
  output logic [7:0] yaw_turn,
  output logic [7:0] thrust_gain,
  output logic [7:0] lamp,
  output logic [7:0] zoom_camera,
  output logic [7:0] gimbal,
  output logic [7:0] manipulator,
  output logic [7:0] motion_enable
);
  import cfp_pkg::*;

  parse_evt_t evt;
  cmd_bytes_t cmd;
  cmd_bytes_t out_cmd;
  logic       in_fire;

  assign rx_ready = !(cmd_valid && evt.at_last);
  assign in_fire  = rx_valid && rx_ready;

  cfp_parser #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .in_fire(in_fire),
    .rx_byte(rx_byte),
    .evt    (evt),
    .cmd    (cmd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (evt.emit) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.emit) begin
      out_cmd <= cmd;
    end
  end

  assign depth_hold    = out_cmd[0];
  assign heading_hold  = out_cmd[1];
  assign fore_aft      = out_cmd[2];
  assign lateral       = out_cmd[3];
  assign vertical      = out_cmd[4];
  assign yaw_turn      = out_cmd[5];
  assign thrust_gain   = out_cmd[6];
  assign lamp          = out_cmd[7];
  assign zoom_camera   = out_cmd[8];
  assign gimbal        = out_cmd[9];
  assign manipulator   = out_cmd[10];
  assign motion_enable = out_cmd[11];

  `include "command_frame_parser_assert.svh"

  `CFP_ASSERT(a_stall_needs_pending, !rx_ready |-> cmd_valid, "Stall with no command waiting.")
  `CFP_ASSERT(a_emit_into_empty, evt.emit |-> !cmd_valid, "Command emitted over a waiting one.")
  `CFP_ASSERT_NEXT(a_emit_shows, evt.emit, cmd_valid && (out_cmd == $past(cmd)), "Command not shown.")

endmodule

// ----- bench/cfp_cmd_checker.sv -----
// ----------------------------------------------------------------------------
// Command frame parser checker
// Watches the rx and cmd channels of the parser, tracks the frame state from
// every byte transfer, queues the command set due from each good frame and
// compares every command transfer against the oldest queued set, field by
// field. The failure count and the number of outstanding sets go to the top.
// ----------------------------------------------------------------------------
module cfp_cmd_checker #(
  parameter int FRAME_LENGTH = cfp_pkg::FRAME_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  input  logic       rx_ready,
  input  logic [7:0] rx_byte,
  input  logic       cmd_valid,
  input  logic       cmd_ready,
  input  logic [7:0] depth_hold,
  input  logic [7:0] heading_hold,
  input  logic [7:0] fore_aft,
  input  logic [7:0] lateral,
  input  logic [7:0] vertical,
  input  logic [7:0] yaw_turn,
  input  logic [7:0] thrust_gain,
  input  logic [7:0] lamp,
  input  logic [7:0] zoom_camera,
  input  logic [7:0] gimbal,
  input  logic [7:0] manipulator,
  input  logic [7:0] motion_enable,
  output int         errors,
  output int         pending,
  output int         delivered
);
  timeunit 1ns;
  timeprecision 1ps;

  import cfp_pkg::*;

  localparam int PAYLOAD_SLOTS = 16;

  logic [POS_W-1:0] frame_pos;
  logic [7:0] sum_acc;
  logic [7:0] payload [PAYLOAD_SLOTS];
  cmd_bytes_t cmd_due_q [$];
  cmd_bytes_t got;
  int err_count = 0;
  int seen = 0;

  string field_name [CMD_COUNT] = '{
    "depth_hold", "heading_hold", "fore_aft", "lateral", "vertical", "yaw_turn",
    "thrust_gain", "lamp", "zoom_camera", "gimbal", "manipulator", "motion_enable"
  };

  assign got = {motion_enable, manipulator, gimbal, zoom_camera, lamp, thrust_gain,
                yaw_turn, vertical, lateral, fore_aft, heading_hold, depth_hold};
  assign errors = err_count;
  assign delivered = seen;

  // The last command field comes from frame byte 18; the others follow byte 3 on.
  function automatic int payload_slot(input int field);
    return (field == CMD_COUNT - 1) ? 15 : field;
  endfunction

  task automatic report(input string msg);
    err_count++;
    $display("[%0t] %s", $realtime, msg);
  endtask

  task automatic track_byte(input logic [7:0] b);
    cmd_bytes_t cmd;
    int slot;
    if (frame_pos == POS_HUNT) begin
      if (b == HDR_FIRST) begin
        frame_pos = POS_SYNC;
        sum_acc = b;
      end
    end else if (frame_pos == POS_SYNC) begin
      if (b == HDR_SECOND) begin
        frame_pos = POS_LEN;
        sum_acc = sum_acc + b;
      end else if (b == HDR_FIRST) begin
        sum_acc = b;
      end else begin
        frame_pos = POS_HUNT;
        sum_acc = '0;
      end
    end else if (frame_pos == POS_LEN) begin
      if (int'(b) == FRAME_LENGTH) begin
        frame_pos = POS_DATA;
        sum_acc = sum_acc + b;
      end else begin
        frame_pos = POS_HUNT;
        sum_acc = '0;
      end
    end else if (int'(frame_pos) < FRAME_LENGTH - 1) begin
      slot = int'(frame_pos) - int'(POS_DATA);
      if (slot < PAYLOAD_SLOTS) payload[slot] = b;
      sum_acc = sum_acc + b;
      frame_pos = frame_pos + 1'b1;
    end else begin
      if (b == sum_acc) begin
        for (int i = 0; i < CMD_COUNT; i++) cmd[i] = payload[payload_slot(i)];
        cmd_due_q.push_back(cmd);
      end
      frame_pos = POS_HUNT;
      sum_acc = '0;
    end
  endtask

  always @(posedge clk) begin
    cmd_bytes_t want;
    if (rst) begin
      frame_pos = POS_HUNT;
      sum_acc = '0;
      cmd_due_q.delete();
    end else begin
      if (cmd_valid && cmd_ready) begin
        seen++;
        if (cmd_due_q.size() == 0) begin
          report($sformatf("command transfer %0d arrived with none due", seen));
        end else begin
          want = cmd_due_q.pop_front();
          for (int i = 0; i < CMD_COUNT; i++) begin
            if (got[i] !== want[i]) begin
              report($sformatf("command transfer %0d: %s is %02h, expected %02h",
                               seen, field_name[i], got[i], want[i]));
            end
          end
        end
      end
      if (rx_valid && rx_ready) track_byte(rx_byte);
    end
    pending <= cmd_due_q.size();
  end

endmodule

// ----- bench/tb_command_frame_parser.sv -----
// ----------------------------------------------------------------------------
// Command frame parser testbench
// Feeds the parser directed header and length corner cases, then a long run
// of random frames: clean ones, corrupted checksums, bad lengths, broken
// headers, frames cut short and loose noise bytes, with random idle cycles
// on both channels, a long consumer hold-off and a full drain pause. The
// checker module does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_command_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FLEN = cfp_pkg::FRAME_LENGTH_DEF;
  localparam int RX_ITEMS = 1050;
  localparam int HOLD_CYCLES = 300;

  typedef enum {FR_GOOD, FR_BAD_SUM, FR_BAD_LEN, FR_BAD_HDR, FR_SHORT} frame_kind_t;
  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_MARKERS} fill_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       cmd_valid;
  logic       cmd_ready = 1'b0;
  logic [7:0] depth_hold;
  logic [7:0] heading_hold;
  logic [7:0] fore_aft;
  logic [7:0] lateral;
  logic [7:0] vertical;
  logic [7:0] yaw_turn;
  logic [7:0] thrust_gain;
  logic [7:0] lamp;
  logic [7:0] zoom_camera;
  logic [7:0] gimbal;
  logic [7:0] manipulator;
  logic [7:0] motion_enable;
  int         errors;
  int         pending;
  int         delivered;

  bit rx_idle = 1'b1;
  bit cmd_idle = 1'b1;
  bit hold_req = 1'b0;
  int bytes_sent = 0;
  int good_sent = 0;
  int bad_sent = 0;
  int broken_sent = 0;

  command_frame_parser #(.FRAME_LENGTH(FLEN)) uut (.*);

  cfp_cmd_checker #(.FRAME_LENGTH(FLEN)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("command_frame_parser: mismatch");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input bit counted);
    int gap;
    gap = rx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!rx_ready);
    if (counted) bytes_sent++;
  endtask

  function automatic logic [7:0] fill_byte(input fill_t fill);
    case (fill)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      FILL_MARKERS: begin
        case ($urandom_range(0, 4))
          0: return cfp_pkg::HDR_FIRST;
          1: return cfp_pkg::HDR_SECOND;
          2: return 8'(FLEN);
          3: return 8'h00;
          default: return 8'hFF;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input frame_kind_t kind, input fill_t fill);
    logic [7:0] fr [64];
    logic [7:0] sum;
    logic [7:0] odd;
    int cut;
    fr[0] = cfp_pkg::HDR_FIRST;
    fr[1] = cfp_pkg::HDR_SECOND;
    fr[2] = 8'(FLEN);
    sum = fr[0] + fr[1] + fr[2];
    for (int i = 3; i < FLEN - 1; i++) begin
      fr[i] = fill_byte(fill);
      sum = sum + fr[i];
    end
    fr[FLEN-1] = sum;
    case (kind)
      FR_GOOD: begin
        good_sent++;
      end
      FR_BAD_SUM: begin
        fr[FLEN-1] = sum ^ 8'($urandom_range(1, 255));
        bad_sent++;
      end
      FR_BAD_LEN: begin
        do odd = ($urandom_range(0, 3) == 0) ? cfp_pkg::HDR_FIRST
                                             : 8'($urandom_range(0, 255));
        while (odd == 8'(FLEN));
        send_byte(fr[0], 1'b1);
        send_byte(fr[1], 1'b1);
        send_byte(odd, 1'b1);
        broken_sent++;
        return;
      end
      FR_BAD_HDR: begin
        do odd = ($urandom_range(0, 2) == 0) ? cfp_pkg::HDR_FIRST
                                             : 8'($urandom_range(0, 255));
        while (odd == cfp_pkg::HDR_SECOND);
        send_byte(cfp_pkg::HDR_FIRST, 1'b1);
        send_byte(odd, 1'b1);
        good_sent++;
      end
      FR_SHORT: begin
        cut = $urandom_range(3, FLEN - 2);
        for (int i = 0; i < cut; i++) send_byte(fr[i], 1'b1);
        broken_sent++;
        return;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < FLEN; i++) send_byte(fr[i], 1'b1);
  endtask

  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) cmd_idle = !cmd_idle;
      if (hold_req) begin
        cmd_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = cmd_idle ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        cmd_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      cmd_ready <= 1'b1;
      do @(posedge clk); while (!cmd_valid);
    end
  end

  initial begin
    int pick;
    int drain;
    fill_t fill;
    bit hold_done;
    bit pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Broken header, repeated first header byte, then a length byte that
    // looks like a header byte, then a clean frame of all-ones commands.
    send_byte(cfp_pkg::HDR_FIRST, 1'b1);
    send_byte(8'h12, 1'b1);
    send_byte(cfp_pkg::HDR_FIRST, 1'b1);
    send_byte(cfp_pkg::HDR_FIRST, 1'b1);
    send_byte(cfp_pkg::HDR_SECOND, 1'b1);
    send_byte(cfp_pkg::HDR_FIRST, 1'b1);
    send_frame(FR_GOOD, FILL_ONES);

    while (bytes_sent < RX_ITEMS) begin
      if (!hold_done && bytes_sent > RX_ITEMS / 3) begin
        hold_done = 1'b1;
        rx_idle = 1'b0;
        hold_req = 1'b1;
        repeat (5) send_frame(FR_GOOD, FILL_RANDOM);
        rx_idle = 1'b1;
      end
      if (!pause_done && bytes_sent > 2 * RX_ITEMS / 3) begin
        pause_done = 1'b1;
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if ($urandom_range(0, 7) == 0) rx_idle = !rx_idle;
      pick = $urandom_range(0, 9);
      fill = (pick < 7) ? FILL_RANDOM : fill_t'(pick - 6);
      pick = $urandom_range(0, 99);
      if (pick < 60) send_frame(FR_GOOD, fill);
      else if (pick < 70) send_frame(FR_BAD_SUM, fill);
      else if (pick < 78) send_frame(FR_BAD_LEN, fill);
      else if (pick < 86) send_frame(FR_BAD_HDR, fill);
      else if (pick < 92) send_frame(FR_SHORT, fill);
      else repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end

    rx_valid <= 1'b0;
    @(posedge clk);
    drain = 0;
    while (pending != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (4) @(posedge clk);

    $display("Drove %0d frame bytes: %0d clean frames, %0d with a corrupted checksum,",
             bytes_sent, good_sent, bad_sent);
    $display("%0d broken or cut short; checked %0d command transfers, %0d field errors.",
             broken_sent, delivered, errors);
    if (pending != 0) $display("%0d expected command sets never arrived.", pending);
    if (errors == 0 && pending == 0) begin
      $display("command_frame_parser: match");
    end else begin
      $display("command_frame_parser: mismatch");
    end
    $finish;
  end

endmodule

// ----- command_frame_parser.f -----
+incdir+hw/rtl
hw/rtl/cfp_pkg.sv
hw/rtl/cfp_parser.sv
hw/rtl/command_frame_parser.sv
bench/cfp_cmd_checker.sv
bench/tb_command_frame_parser.sv
